@@ design/vms_pkg.sv @@
// ----------------------------------------------------------------------------
// vms_pkg
// Shared types, widths and codes for the velocity mean and spread unit.
// ----------------------------------------------------------------------------
package vms_pkg;

	localparam int MAX_PARTICLES = 4096;
	localparam int MAX_FRAMES    = 1024;

	localparam int VW    = 16;          // velocity and result field width
	localparam int NCW   = 13;          // particle count width
	localparam int FCW   = 11;          // frame count width
	localparam int CFG_W = 13;          // config write data width
	localparam int MW    = 23;          // N*F width
	localparam int SQ_W  = 31;          // one velocity squared
	localparam int FS_W  = 28;          // frame sum
	localparam int FQ_W  = 44;          // frame sum of squares
	localparam int TS_W  = 38;          // total sum
	localparam int TQ_W  = 54;          // total sum of squares
	localparam int MA_W  = 54;          // multiplicand width
	localparam int MB_W  = 38;          // multiplier width
	localparam int PW    = 92;          // product width
	localparam int DVW   = 78;          // dividend and quotient width
	localparam int DSW   = 45;          // divisor width
	localparam int SQW   = 64;          // square root input width
	localparam int RTW   = 32;          // square root result width
	localparam int SRW   = 34;          // square root remainder width
	localparam int CNT_W = 7;           // iteration counter width

	typedef enum logic [0:0] {
		CFG_PARTICLE_COUNT,
		CFG_FRAME_COUNT
	} cfg_idx_t;

	typedef struct packed {
		logic signed [VW-1:0] u_vel;
		logic signed [VW-1:0] v_vel;
		logic signed [VW-1:0] w_vel;
	} in_item_t;

	typedef struct packed {
		logic signed [VW-1:0] u_mean;
		logic signed [VW-1:0] v_mean;
		logic signed [VW-1:0] w_mean;
		logic [VW-1:0]        u_sdev;
		logic [VW-1:0]        v_sdev;
		logic [VW-1:0]        w_sdev;
		logic [VW-1:0]        vertical_rms;
		logic [VW-1:0]        horizontal_rms;
		logic                 overall_valid;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FLUSH,
		ST_N2,
		ST_M2,
		ST_MEAN,
		ST_MA,
		ST_MB,
		ST_VDIV,
		ST_ROOT,
		ST_LOAD
	} st_t;

	typedef enum logic [2:0] {
		UOP_N2,
		UOP_M2,
		UOP_MEAN,
		UOP_MA,
		UOP_MB,
		UOP_VDIV,
		UOP_ROOT
	} uop_t;

	typedef enum logic [1:0] {
		AOP_MUL,
		AOP_DIV,
		AOP_SQRT
	} aop_t;

	localparam logic [1:0] COMP_U = 2'd0;
	localparam logic [1:0] COMP_V = 2'd1;
	localparam logic [1:0] COMP_W = 2'd2;

	typedef struct packed {
		logic       take;
		logic       flush;
		logic       start;
		logic       store;
		uop_t       op;
		logic [1:0] comp;
		logic       tot;
		logic       load;
	} cmd_t;

	typedef struct packed {
		logic frame_end;
		logic last;
		logic done;
		logic out_free;
	} stat_t;

endpackage

@@ design/vms_arith.sv @@
// ----------------------------------------------------------------------------
// vms_arith
// Shared iterative unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
module vms_arith (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  vms_pkg::aop_t             op,
	input  logic [vms_pkg::DVW-1:0]   a,
	input  logic [vms_pkg::DSW-1:0]   b,
	output logic                      busy,
	output logic                      done,
	output logic [vms_pkg::PW-1:0]    prod,
	output logic [vms_pkg::DVW-1:0]   quot,
	output logic                      rem_nz,
	output logic [vms_pkg::RTW-1:0]   root
);

	logic                        busy_q;
	logic                        done_q;
	vms_pkg::aop_t               op_q;
	logic [vms_pkg::CNT_W-1:0]   cnt_q;
	logic [vms_pkg::CNT_W-1:0]   last_cnt;
	logic [vms_pkg::PW-1:0]      acc_q;
	logic [vms_pkg::PW-1:0]      mc_q;
	logic [vms_pkg::MB_W-1:0]    mb_q;
	logic [vms_pkg::DVW-1:0]     dq_q;
	logic [vms_pkg::DSW-1:0]     rem_q;
	logic [vms_pkg::DSW-1:0]     dv_q;
	logic [vms_pkg::SRW-1:0]     sr_q;
	logic [vms_pkg::RTW-1:0]     rt_q;
	logic [vms_pkg::DSW:0]       dt;
	logic [vms_pkg::DSW:0]       dsub;
	logic                        dge;
	logic [vms_pkg::SRW+1:0]     st;
	logic [vms_pkg::SRW+1:0]     trial;
	logic [vms_pkg::SRW+1:0]     ssub;
	logic                        sge;

	always_comb begin
		dt    = {rem_q, dq_q[vms_pkg::DVW-1]};
		dsub  = dt - {1'b0, dv_q};
		dge   = dt >= {1'b0, dv_q};
		st    = {sr_q, dq_q[vms_pkg::DVW-1 -: 2]};
		trial = {2'b00, rt_q, 2'b01};
		ssub  = st - trial;
		sge   = st >= trial;
		case (op_q)
			vms_pkg::AOP_MUL:  last_cnt = vms_pkg::CNT_W'(vms_pkg::MB_W - 1);
			vms_pkg::AOP_DIV:  last_cnt = vms_pkg::CNT_W'(vms_pkg::DVW - 1);
			default:           last_cnt = vms_pkg::CNT_W'(vms_pkg::SQW / 2 - 1);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= vms_pkg::AOP_MUL;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				op_q   <= op;
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == last_cnt) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			case (op)
				vms_pkg::AOP_MUL: begin
					acc_q <= '0;
					mc_q  <= vms_pkg::PW'(a[vms_pkg::MA_W-1:0]);
					mb_q  <= b[vms_pkg::MB_W-1:0];
				end
				vms_pkg::AOP_DIV: begin
					dq_q  <= a;
					rem_q <= '0;
					dv_q  <= b;
				end
				default: begin
					dq_q <= {a[vms_pkg::SQW-1:0], (vms_pkg::DVW - vms_pkg::SQW)'(0)};
					sr_q <= '0;
					rt_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				vms_pkg::AOP_MUL: begin
					if (mb_q[0]) acc_q <= acc_q + mc_q;
					mc_q <= mc_q << 1;
					mb_q <= mb_q >> 1;
				end
				vms_pkg::AOP_DIV: begin
					rem_q <= dge ? dsub[vms_pkg::DSW-1:0] : dt[vms_pkg::DSW-1:0];
					dq_q  <= {dq_q[vms_pkg::DVW-2:0], dge};
				end
				default: begin
					sr_q <= sge ? ssub[vms_pkg::SRW-1:0] : st[vms_pkg::SRW-1:0];
					rt_q <= {rt_q[vms_pkg::RTW-2:0], sge};
					dq_q <= dq_q << 2;
				end
			endcase
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign prod   = acc_q;
	assign quot   = dq_q;
	assign rem_nz = |rem_q;
	assign root   = rt_q;

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("done held for more than one cycle");
`endif

endmodule

@@ design/vms_dp.sv @@
// ----------------------------------------------------------------------------
// vms_dp
// Datapath: config, accumulators, frame-end operand selection, result regs.
// ----------------------------------------------------------------------------
module vms_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  vms_pkg::cfg_idx_t           cfg_index,
	input  logic [vms_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	input  vms_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output vms_pkg::out_item_t          out_data,
	input  vms_pkg::cmd_t               cmd,
	output vms_pkg::stat_t              stat
);

	logic [vms_pkg::NCW-1:0]          pc_q;
	logic [vms_pkg::FCW-1:0]          fc_q;
	logic [vms_pkg::NCW-1:0]          n_eff;
	logic [vms_pkg::FCW-1:0]          f_eff;
	logic [vms_pkg::NCW-1:0]          pcnt_q;
	logic [vms_pkg::FCW-1:0]          fcnt_q;
	logic                             last_q;
	logic [vms_pkg::MW-1:0]           m_q;
	logic                             acc_en;
	logic                             frame_end;
	logic                             v_s1;
	logic signed [vms_pkg::VW-1:0]    x_s1 [3];
	logic signed [vms_pkg::FS_W-1:0]  fsum_q [3];
	logic [vms_pkg::FQ_W-1:0]         fsq_q [3];
	logic signed [vms_pkg::TS_W-1:0]  tsum_q [3];
	logic [vms_pkg::TQ_W-1:0]         tsq_q [3];
	logic signed [2*vms_pkg::VW-1:0]  sq [3];
	logic [vms_pkg::DSW-1:0]          n2_q;
	logic [vms_pkg::DSW-1:0]          m2_q;
	logic [vms_pkg::DVW-1:0]          pa_q;
	logic [vms_pkg::DVW-1:0]          var_q;
	logic [vms_pkg::DVW-1:0]          hnum_q;
	logic [vms_pkg::DVW-1:0]          q_q;
	logic [vms_pkg::VW-1:0]           mean_q [3];
	logic [vms_pkg::VW-1:0]           sdev_q [3];
	logic [vms_pkg::VW-1:0]           vrms_q;
	logic [vms_pkg::VW-1:0]           hrms_q;
	logic                             out_valid_q;
	vms_pkg::out_item_t               out_q;
	logic                             out_free;

	logic signed [vms_pkg::TS_W-1:0]  fs_ext;
	logic signed [vms_pkg::TS_W-1:0]  sel_sum;
	logic [vms_pkg::MB_W-1:0]         mag_f;
	logic [vms_pkg::MB_W-1:0]         mag_sel;
	logic [vms_pkg::DVW-1:0]          diff;
	logic [vms_pkg::VW-1:0]           qn;
	logic [vms_pkg::VW-1:0]           rt16;
	logic                             h_path;

	vms_pkg::aop_t                    ar_op;
	logic [vms_pkg::DVW-1:0]          ar_a;
	logic [vms_pkg::DSW-1:0]          ar_b;
	logic                             ar_busy;
	logic                             ar_done;
	logic [vms_pkg::PW-1:0]           ar_prod;
	logic [vms_pkg::DVW-1:0]          ar_quot;
	logic                             ar_rem_nz;
	logic [vms_pkg::RTW-1:0]          ar_root;

	// Effective counts: zero acts as one, large values saturate.
	always_comb begin
		if (pc_q == '0)
			n_eff = vms_pkg::NCW'(1);
		else if (pc_q > vms_pkg::NCW'(vms_pkg::MAX_PARTICLES))
			n_eff = vms_pkg::NCW'(vms_pkg::MAX_PARTICLES);
		else
			n_eff = pc_q;
		if (fc_q == '0)
			f_eff = vms_pkg::FCW'(1);
		else if (fc_q > vms_pkg::FCW'(vms_pkg::MAX_FRAMES))
			f_eff = vms_pkg::FCW'(vms_pkg::MAX_FRAMES);
		else
			f_eff = fc_q;
	end

	assign acc_en    = in_valid & cmd.take;
	assign frame_end = acc_en & ((pcnt_q + 1'b1) >= n_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= vms_pkg::NCW'(1);
			fc_q <= vms_pkg::FCW'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				vms_pkg::CFG_PARTICLE_COUNT: pc_q <= cfg_wdata[vms_pkg::NCW-1:0];
				vms_pkg::CFG_FRAME_COUNT:    fc_q <= cfg_wdata[vms_pkg::FCW-1:0];
				default: ;
			endcase
		end
	end

	// Counters, input stage and accumulators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pcnt_q <= '0;
			fcnt_q <= '0;
			last_q <= 1'b0;
			v_s1   <= 1'b0;
			m_q    <= '0;
			for (int k = 0; k < 3; k++) begin
				fsum_q[k] <= '0;
				fsq_q[k]  <= '0;
				tsum_q[k] <= '0;
				tsq_q[k]  <= '0;
			end
		end else begin
			v_s1 <= acc_en;
			if (acc_en) pcnt_q <= frame_end ? '0 : pcnt_q + 1'b1;
			if (cmd.flush) begin
				last_q <= (fcnt_q + 1'b1) >= f_eff;
				fcnt_q <= ((fcnt_q + 1'b1) >= f_eff) ? '0 : fcnt_q + 1'b1;
				m_q    <= vms_pkg::MW'(n_eff) * vms_pkg::MW'(f_eff);
			end
			if (v_s1) begin
				for (int k = 0; k < 3; k++) begin
					fsum_q[k] <= fsum_q[k] + vms_pkg::FS_W'(x_s1[k]);
					fsq_q[k]  <= fsq_q[k] + vms_pkg::FQ_W'(sq[k][vms_pkg::SQ_W-1:0]);
					tsum_q[k] <= tsum_q[k] + vms_pkg::TS_W'(x_s1[k]);
					tsq_q[k]  <= tsq_q[k] + vms_pkg::TQ_W'(sq[k][vms_pkg::SQ_W-1:0]);
				end
			end else if (cmd.load) begin
				for (int k = 0; k < 3; k++) begin
					fsum_q[k] <= '0;
					fsq_q[k]  <= '0;
					if (last_q) begin
						tsum_q[k] <= '0;
						tsq_q[k]  <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			x_s1[0] <= in_data.u_vel;
			x_s1[1] <= in_data.v_vel;
			x_s1[2] <= in_data.w_vel;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) sq[k] = x_s1[k] * x_s1[k];
	end

	// Operand selection for the shared unit.
	always_comb begin
		fs_ext  = vms_pkg::TS_W'(fsum_q[cmd.comp]);
		mag_f   = fs_ext[vms_pkg::TS_W-1] ? vms_pkg::MB_W'(-fs_ext) : vms_pkg::MB_W'(fs_ext);
		sel_sum = cmd.tot ? tsum_q[cmd.comp] : fs_ext;
		mag_sel = sel_sum[vms_pkg::TS_W-1] ? vms_pkg::MB_W'(-sel_sum)
			: vms_pkg::MB_W'(sel_sum);
		h_path  = cmd.tot && (cmd.comp != vms_pkg::COMP_W);
		ar_op   = vms_pkg::AOP_MUL;
		ar_a    = '0;
		ar_b    = '0;
		unique case (cmd.op)
			vms_pkg::UOP_N2: begin
				ar_a = vms_pkg::DVW'(n_eff);
				ar_b = vms_pkg::DSW'(n_eff);
			end
			vms_pkg::UOP_M2: begin
				ar_a = vms_pkg::DVW'(m_q);
				ar_b = vms_pkg::DSW'(m_q);
			end
			vms_pkg::UOP_MEAN: begin
				ar_op = vms_pkg::AOP_DIV;
				ar_a  = vms_pkg::DVW'(mag_f);
				ar_b  = vms_pkg::DSW'(n_eff);
			end
			vms_pkg::UOP_MA: begin
				ar_a = cmd.tot ? vms_pkg::DVW'(tsq_q[cmd.comp]) : vms_pkg::DVW'(fsq_q[cmd.comp]);
				ar_b = cmd.tot ? vms_pkg::DSW'(m_q) : vms_pkg::DSW'(n_eff);
			end
			vms_pkg::UOP_MB: begin
				ar_a = vms_pkg::DVW'(mag_sel);
				ar_b = vms_pkg::DSW'(mag_sel);
			end
			vms_pkg::UOP_VDIV: begin
				ar_op = vms_pkg::AOP_DIV;
				ar_a  = h_path ? hnum_q : var_q;
				ar_b  = cmd.tot ? m2_q : n2_q;
			end
			vms_pkg::UOP_ROOT: begin
				ar_op = vms_pkg::AOP_SQRT;
				ar_a  = vms_pkg::DVW'(q_q[vms_pkg::SQW-1:0]);
			end
			default: ;
		endcase
		// Clamp the spread numerator at zero.
		diff = (pa_q >= ar_prod[vms_pkg::DVW-1:0]) ? pa_q - ar_prod[vms_pkg::DVW-1:0] : '0;
		qn   = ar_quot[vms_pkg::VW-1:0] + vms_pkg::VW'(ar_rem_nz);
		rt16 = (|q_q[vms_pkg::DVW-1:vms_pkg::SQW]) ? {vms_pkg::VW{1'b1}}
			: ar_root[vms_pkg::VW-1:0];
	end

	vms_arith u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.op     (ar_op),
		.a      (ar_a),
		.b      (ar_b),
		.busy   (ar_busy),
		.done   (ar_done),
		.prod   (ar_prod),
		.quot   (ar_quot),
		.rem_nz (ar_rem_nz),
		.root   (ar_root)
	);

	// Capture results of each step.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			unique case (cmd.op)
				vms_pkg::UOP_N2:   n2_q <= ar_prod[vms_pkg::DSW-1:0];
				vms_pkg::UOP_M2:   m2_q <= ar_prod[vms_pkg::DSW-1:0];
				vms_pkg::UOP_MEAN: mean_q[cmd.comp] <= fsum_q[cmd.comp][vms_pkg::FS_W-1]
					? -qn : ar_quot[vms_pkg::VW-1:0];
				vms_pkg::UOP_MA:   pa_q <= ar_prod[vms_pkg::DVW-1:0];
				vms_pkg::UOP_MB: begin
					if (cmd.tot && cmd.comp == vms_pkg::COMP_U)
						hnum_q <= diff;
					else if (cmd.tot && cmd.comp == vms_pkg::COMP_V)
						hnum_q <= hnum_q + diff;
					else
						var_q <= diff;
				end
				vms_pkg::UOP_VDIV: q_q <= h_path ? ar_quot >> 1 : ar_quot;
				vms_pkg::UOP_ROOT: begin
					if (!cmd.tot)
						sdev_q[cmd.comp] <= rt16;
					else if (cmd.comp == vms_pkg::COMP_W)
						vrms_q <= rt16;
					else
						hrms_q <= rt16;
				end
				default: ;
			endcase
		end
	end

	// Output register.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q.u_mean         <= mean_q[0];
			out_q.v_mean         <= mean_q[1];
			out_q.w_mean         <= mean_q[2];
			out_q.u_sdev         <= sdev_q[0];
			out_q.v_sdev         <= sdev_q[1];
			out_q.w_sdev         <= sdev_q[2];
			out_q.vertical_rms   <= last_q ? vrms_q : '0;
			out_q.horizontal_rms <= last_q ? hrms_q : '0;
			out_q.overall_valid  <= last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_data       = out_q;
	assign stat.frame_end = frame_end;
	assign stat.last      = last_q;
	assign stat.done      = ar_done;
	assign stat.out_free  = out_free;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !ar_busy)
		else $error("arithmetic unit started while busy");
`endif

endmodule

@@ design/vms_ctrl.sv @@
// ----------------------------------------------------------------------------
// vms_ctrl
// Controller: accepts items and sequences the frame-end computation.
// ----------------------------------------------------------------------------
module vms_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  vms_pkg::stat_t  stat,
	output vms_pkg::cmd_t   cmd
);

	vms_pkg::st_t  state_q, state_n;
	logic [1:0]    comp_q, comp_n;
	logic          tot_q, tot_n;
	logic          issued_q, issued_n;
	logic          step_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= vms_pkg::ST_IDLE;
			comp_q   <= vms_pkg::COMP_U;
			tot_q    <= 1'b0;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_n;
			comp_q   <= comp_n;
			tot_q    <= tot_n;
			issued_q <= issued_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		comp_n    = comp_q;
		tot_n     = tot_q;
		issued_n  = issued_q;
		cmd       = '0;
		cmd.op    = vms_pkg::UOP_N2;
		cmd.comp  = comp_q;
		cmd.tot   = tot_q;
		step_done = 1'b0;
		// Issue the step once, then wait for the unit to finish it.
		if (state_q != vms_pkg::ST_IDLE && state_q != vms_pkg::ST_FLUSH
				&& state_q != vms_pkg::ST_LOAD) begin
			if (!issued_q) begin
				cmd.start = 1'b1;
				issued_n  = 1'b1;
			end else if (stat.done) begin
				cmd.store = 1'b1;
				issued_n  = 1'b0;
				step_done = 1'b1;
			end
		end
		unique case (state_q)
			vms_pkg::ST_IDLE: begin
				cmd.take = 1'b1;
				if (stat.frame_end) state_n = vms_pkg::ST_FLUSH;
			end
			vms_pkg::ST_FLUSH: begin
				cmd.flush = 1'b1;
				comp_n    = vms_pkg::COMP_U;
				tot_n     = 1'b0;
				state_n   = vms_pkg::ST_N2;
			end
			vms_pkg::ST_N2: begin
				cmd.op = vms_pkg::UOP_N2;
				if (step_done) state_n = stat.last ? vms_pkg::ST_M2 : vms_pkg::ST_MEAN;
			end
			vms_pkg::ST_M2: begin
				cmd.op = vms_pkg::UOP_M2;
				if (step_done) state_n = vms_pkg::ST_MEAN;
			end
			vms_pkg::ST_MEAN: begin
				cmd.op = vms_pkg::UOP_MEAN;
				if (step_done) state_n = vms_pkg::ST_MA;
			end
			vms_pkg::ST_MA: begin
				cmd.op = vms_pkg::UOP_MA;
				if (step_done) state_n = vms_pkg::ST_MB;
			end
			vms_pkg::ST_MB: begin
				cmd.op = vms_pkg::UOP_MB;
				if (step_done) begin
					if (tot_q && comp_q == vms_pkg::COMP_U) begin
						comp_n  = vms_pkg::COMP_V;
						state_n = vms_pkg::ST_MA;
					end else begin
						state_n = vms_pkg::ST_VDIV;
					end
				end
			end
			vms_pkg::ST_VDIV: begin
				cmd.op = vms_pkg::UOP_VDIV;
				if (step_done) state_n = vms_pkg::ST_ROOT;
			end
			vms_pkg::ST_ROOT: begin
				cmd.op = vms_pkg::UOP_ROOT;
				if (step_done) begin
					if (!tot_q) begin
						if (comp_q != vms_pkg::COMP_W) begin
							comp_n  = comp_q + 1'b1;
							state_n = vms_pkg::ST_MEAN;
						end else if (stat.last) begin
							tot_n   = 1'b1;
							state_n = vms_pkg::ST_MA;
						end else begin
							state_n = vms_pkg::ST_LOAD;
						end
					end else if (comp_q == vms_pkg::COMP_W) begin
						comp_n  = vms_pkg::COMP_U;
						state_n = vms_pkg::ST_MA;
					end else begin
						state_n = vms_pkg::ST_LOAD;
					end
				end
			end
			vms_pkg::ST_LOAD: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					state_n  = vms_pkg::ST_IDLE;
				end
			end
			default: state_n = vms_pkg::ST_IDLE;
		endcase
	end

endmodule

@@ design/velocity_mean_and_spread_unit.sv @@
// ----------------------------------------------------------------------------
// velocity_mean_and_spread_unit
// Per-frame mean and standard deviation of particle velocities, with the
// overall vertical and horizontal RMS spread at the end of each period.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one particle's
//   u, v, w velocity per transfer. Within a frame the block takes one
//   transfer every cycle; each one is summed the cycle after it is taken.
//   When a transfer completes a frame, in_stall rises while the shared
//   multiply / divide / root unit works out the results, with the overall
//   spread steps added when the frame closes a period.
//   That stall is set by the single iterative unit doing one bit per cycle.
//   Output channel (out_valid / out_stall / out_data) gives one result per
//   frame from an output register; the next frame is accepted while it
//   waits. If the receiver still stalls the previous result when the next
//   frame's results are ready, the block holds them and keeps in_stall high.
//   Config writes (cfg_wr_en, cfg_index, cfg_wdata) take effect at once and
//   belong to idle periods only.
//   Reset clears all sums and counters, sets both counts to one and drops
//   out_valid.
// ----------------------------------------------------------------------------
module velocity_mean_and_spread_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  vms_pkg::cfg_idx_t           cfg_index,
	input  logic [vms_pkg::CFG_W-1:0]   cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  vms_pkg::in_item_t           in_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output vms_pkg::out_item_t          out_data
);

	vms_pkg::cmd_t   cmd;
	vms_pkg::stat_t  stat;

	// Controller: sequences accept, flush and the frame-end steps.
	vms_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.cmd    (cmd)
	);

	// Datapath: sums, shared arithmetic unit, result and output registers.
	vms_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	// Stall input whenever the controller is not collecting particles.
	assign in_stall = !cmd.take;

`ifndef SYNTH
	a_overall_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.overall_valid) |->
		(out_data.vertical_rms == '0 && out_data.horizontal_rms == '0))
		else $error("overall spread nonzero on a non-final frame");
`endif

endmodule
